@@ src/frustum_cull_test_core_macros.svh @@
// Assertion macros for the frustum cull test checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef FRUSTUM_CULL_TEST_CORE_MACROS_SVH
`define FRUSTUM_CULL_TEST_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FCULL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FCULL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/fcull_pkg.sv @@
// Shared types and constants for the frustum cull test core.
// No dependencies; used by every other file of the block but the macro header.
`timescale 1ns / 1ps

package fcull_pkg;

    localparam int PLANE_COUNT_DEF = 6;
    localparam int REG_COUNT       = 6;
    localparam int COORD_W         = 16;
    localparam int RADIUS_W        = 15;
    localparam int PROD_W          = 32;
    localparam int DIST_W          = 34;
    localparam int FRAC_SHIFT      = 14;
    localparam int CACHE_W         = 4;
    localparam int ADDR_W          = 6;
    localparam int DATA_W          = 64;
    localparam int IDX_W           = 3;

    localparam logic [1:0] KIND_SPHERE = 2'd1;
    localparam logic [1:0] KIND_BOX    = 2'd2;

    localparam logic [CACHE_W-1:0] CACHE_NONE = 4'b1111;

    typedef enum logic [1:0] {
        VERDICT_IN    = 2'd0,
        VERDICT_ISECT = 2'd1,
        VERDICT_OUT   = 2'd2
    } verdict_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [1:0]          kind;
        coord_t [2:0]        lo;
        coord_t [2:0]        hi;
        logic [RADIUS_W-1:0] radius;
    } prim_t;

endpackage

@@ src/fcull_lane.sv @@
// One plane lane of the frustum cull test: registered normal products for the
// positive and negative vertex, then distance and per-plane classification.
// Depends on fcull_pkg.
`timescale 1ns / 1ps

module fcull_lane
(
    input  logic                            clk,
    input  logic                            en,
    input  fcull_pkg::prim_t                prim,
    input  logic [fcull_pkg::DATA_W-1:0]    plane,
    input  logic [1:0]                      kind_s2,
    input  logic [fcull_pkg::RADIUS_W-1:0]  radius_s2,
    output fcull_pkg::verdict_t             verdict
);

    logic signed [fcull_pkg::COORD_W-1:0] nrm [3];
    logic signed [fcull_pkg::COORD_W-1:0] pv_sel [3];
    logic signed [fcull_pkg::COORD_W-1:0] nv_sel [3];
    logic signed [fcull_pkg::PROD_W-1:0]  pv_prod_next [3];
    logic signed [fcull_pkg::PROD_W-1:0]  nv_prod_next [3];
    logic signed [fcull_pkg::PROD_W-1:0]  pv_prod_reg [3];
    logic signed [fcull_pkg::PROD_W-1:0]  nv_prod_reg [3];
    logic signed [fcull_pkg::COORD_W-1:0] d_coef;
    logic signed [fcull_pkg::DIST_W-1:0]  d_term;
    logic signed [fcull_pkg::DIST_W-1:0]  rad_term;
    logic signed [fcull_pkg::DIST_W-1:0]  dist_pv;
    logic signed [fcull_pkg::DIST_W-1:0]  dist_nv;
    logic signed [fcull_pkg::DIST_W-1:0]  dist_abs;
    logic                                 is_box;

    assign is_box = (prim.kind == fcull_pkg::KIND_BOX);

    // For points and spheres the positive-vertex path carries the position itself.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            nrm[a]    = $signed(plane[a*fcull_pkg::COORD_W +: fcull_pkg::COORD_W]);
            pv_sel[a] = (is_box && !nrm[a][fcull_pkg::COORD_W-1]) ?
                        $signed(prim.hi[a]) : $signed(prim.lo[a]);
            nv_sel[a] = nrm[a][fcull_pkg::COORD_W-1] ?
                        $signed(prim.hi[a]) : $signed(prim.lo[a]);
            pv_prod_next[a] = fcull_pkg::PROD_W'(nrm[a]) * fcull_pkg::PROD_W'(pv_sel[a]);
            nv_prod_next[a] = fcull_pkg::PROD_W'(nrm[a]) * fcull_pkg::PROD_W'(nv_sel[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                pv_prod_reg[a] <= pv_prod_next[a];
                nv_prod_reg[a] <= nv_prod_next[a];
            end
        end
    end

    // The user is to change plane registers only while idle; the block does not enforce it. d is read live.
    assign d_coef   = $signed(plane[3*fcull_pkg::COORD_W +: fcull_pkg::COORD_W]);
    assign d_term   = fcull_pkg::DIST_W'(d_coef) <<< fcull_pkg::FRAC_SHIFT;
    assign rad_term = $signed({{(fcull_pkg::DIST_W - fcull_pkg::RADIUS_W
                                 - fcull_pkg::FRAC_SHIFT){1'b0}},
                               radius_s2, {fcull_pkg::FRAC_SHIFT{1'b0}}});

    assign dist_pv = fcull_pkg::DIST_W'(pv_prod_reg[0]) + fcull_pkg::DIST_W'(pv_prod_reg[1])
                   + fcull_pkg::DIST_W'(pv_prod_reg[2]) + d_term;
    assign dist_nv = fcull_pkg::DIST_W'(nv_prod_reg[0]) + fcull_pkg::DIST_W'(nv_prod_reg[1])
                   + fcull_pkg::DIST_W'(nv_prod_reg[2]) + d_term;
    assign dist_abs = dist_pv[fcull_pkg::DIST_W-1] ? -dist_pv : dist_pv;

    always_comb
    begin
        unique case (kind_s2)
            fcull_pkg::KIND_SPHERE:
            begin
                if (dist_pv < -rad_term)
                    verdict = fcull_pkg::VERDICT_OUT;
                else if (dist_abs < rad_term)
                    verdict = fcull_pkg::VERDICT_ISECT;
                else
                    verdict = fcull_pkg::VERDICT_IN;
            end
            fcull_pkg::KIND_BOX:
            begin
                if (dist_pv < 0)
                    verdict = fcull_pkg::VERDICT_OUT;
                else if (dist_nv < 0)
                    verdict = fcull_pkg::VERDICT_ISECT;
                else
                    verdict = fcull_pkg::VERDICT_IN;
            end
            // Points, and the unused kind code, which behaves as a point.
            default:
            begin
                if (dist_pv < 0)
                    verdict = fcull_pkg::VERDICT_OUT;
                else if (dist_pv == 0)
                    verdict = fcull_pkg::VERDICT_ISECT;
                else
                    verdict = fcull_pkg::VERDICT_IN;
            end
        endcase
    end

endmodule

@@ src/frustum_cull_test_core.sv @@
// A request passes through the input, product and result registers; out_stall
// can hold it in any of them. Throughput: one request per cycle while the output
// is not stalled; set by the single multiply stage per lane.
// Reset (rst_n, asynchronous, active low) empties the pipeline and clears all
// plane registers to zero. Top level; depends on fcull_pkg and fcull_lane.
`timescale 1ns / 1ps

module frustum_cull_test_core #(
    parameter int PLANE_COUNT = fcull_pkg::PLANE_COUNT_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        kind,
    input  logic signed [15:0]                pos_x,
    input  logic signed [15:0]                pos_y,
    input  logic signed [15:0]                pos_z,
    input  logic signed [15:0]                far_x,
    input  logic signed [15:0]                far_y,
    input  logic signed [15:0]                far_z,
    input  logic [14:0]                       radius,
    input  logic signed [3:0]                 cache_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        verdict,
    output logic signed [3:0]                 cache_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fcull_pkg::ADDR_W-1:0]      paddr,
    input  logic [fcull_pkg::DATA_W-1:0]      pwdata,
    output logic [fcull_pkg::DATA_W-1:0]      prdata,
    output logic                              pready
);

    logic [fcull_pkg::DATA_W-1:0]   plane_reg [fcull_pkg::REG_COUNT];
    logic [fcull_pkg::IDX_W-1:0]    cfg_idx;
    logic                           cfg_in_range;

    fcull_pkg::prim_t               prim_reg;
    logic [fcull_pkg::CACHE_W-1:0]  cache_s1_reg;
    logic                           v1_reg;
    logic [1:0]                     kind_s2_reg;
    logic [fcull_pkg::RADIUS_W-1:0] radius_s2_reg;
    logic [fcull_pkg::CACHE_W-1:0]  cache_s2_reg;
    logic                           v2_reg;
    fcull_pkg::verdict_t            verdict_reg;
    fcull_pkg::verdict_t            verdict_next;
    logic [fcull_pkg::CACHE_W-1:0]  cache_out_reg;
    logic [fcull_pkg::CACHE_W-1:0]  cache_out_next;
    logic                           v3_reg;

    logic                           adv1;
    logic                           adv2;
    logic                           adv3;

    fcull_pkg::verdict_t            lane_verdict [PLANE_COUNT];

    // Configuration port.
    assign pready       = 1'b1;
    assign cfg_idx      = paddr[fcull_pkg::ADDR_W-1 -: fcull_pkg::IDX_W];
    assign cfg_in_range = (int'(cfg_idx) < fcull_pkg::REG_COUNT);
    assign prdata       = cfg_in_range ? plane_reg[cfg_idx] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fcull_pkg::REG_COUNT; i++)
                plane_reg[i] <= '0;
        end
        else if (psel && penable && pwrite && cfg_in_range)
        begin
            plane_reg[cfg_idx] <= pwdata;
        end
    end

    // A stage moves forward when it is empty or the stage after it moves.
    assign adv3     = !v3_reg || !out_stall;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_stall = !adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= in_valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            prim_reg.kind   <= kind;
            prim_reg.lo[0]  <= pos_x;
            prim_reg.lo[1]  <= pos_y;
            prim_reg.lo[2]  <= pos_z;
            prim_reg.hi[0]  <= far_x;
            prim_reg.hi[1]  <= far_y;
            prim_reg.hi[2]  <= far_z;
            prim_reg.radius <= radius;
            cache_s1_reg    <= cache_in;
        end
        if (adv2)
        begin
            kind_s2_reg   <= prim_reg.kind;
            radius_s2_reg <= prim_reg.radius;
            cache_s2_reg  <= cache_s1_reg;
        end
        if (adv3)
        begin
            verdict_reg   <= verdict_next;
            cache_out_reg <= cache_out_next;
        end
    end

    // Planes without a register have all-zero coefficients.
    for (genvar g = 0; g < PLANE_COUNT; g++)
    begin : g_lane
        logic [fcull_pkg::DATA_W-1:0] lane_plane;

        if (g < fcull_pkg::REG_COUNT)
        begin : g_reg
            assign lane_plane = plane_reg[g];
        end
        else
        begin : g_zero
            assign lane_plane = '0;
        end

        fcull_lane u_lane (
            .clk       (clk),
            .en        (adv2),
            .prim      (prim_reg),
            .plane     (lane_plane),
            .kind_s2   (kind_s2_reg),
            .radius_s2 (radius_s2_reg),
            .verdict   (lane_verdict[g])
        );
    end

    // The cached plane wins when it does not report inside; otherwise the lowest
    // plane that does not report inside. A cache code that matches no plane,
    // negative or too large, simply never matches.
    always_comb
    begin
        verdict_next   = fcull_pkg::VERDICT_IN;
        cache_out_next = fcull_pkg::CACHE_NONE;
        for (int i = PLANE_COUNT - 1; i >= 0; i--)
        begin
            if (lane_verdict[i] != fcull_pkg::VERDICT_IN)
            begin
                verdict_next   = lane_verdict[i];
                cache_out_next = fcull_pkg::CACHE_W'(i);
            end
        end
        for (int i = 0; i < PLANE_COUNT; i++)
        begin
            if (cache_s2_reg == fcull_pkg::CACHE_W'(i)
                && lane_verdict[i] != fcull_pkg::VERDICT_IN)
            begin
                verdict_next   = lane_verdict[i];
                cache_out_next = fcull_pkg::CACHE_W'(i);
            end
        end
    end

    assign out_valid = v3_reg;
    assign verdict   = verdict_reg;
    assign cache_out = cache_out_reg;

endmodule

@@ src/fcull_checker.sv @@
// Port-level checks for frustum_cull_test_core, attached by the bind below.
// Depends on fcull_pkg and frustum_cull_test_core_macros.svh.
`timescale 1ns / 1ps
`include "frustum_cull_test_core_macros.svh"

module fcull_checker #(
    parameter int PLANE_COUNT = fcull_pkg::PLANE_COUNT_DEF
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic [1:0]        verdict,
    input logic signed [3:0] cache_out
);

    `FCULL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(verdict) && $stable(cache_out), "stalled result changed")

    `FCULL_ASSERT_NOW(a_inside_no_cache, out_valid && verdict == fcull_pkg::VERDICT_IN, cache_out == fcull_pkg::CACHE_NONE, "inside result carries a plane index")

    `FCULL_ASSERT_NOW(a_reject_plane, out_valid && verdict != fcull_pkg::VERDICT_IN, !cache_out[3] && int'(cache_out[2:0]) < PLANE_COUNT, "rejecting plane index out of range")

endmodule

bind frustum_cull_test_core fcull_checker #(
    .PLANE_COUNT (PLANE_COUNT)
) u_fcull_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .verdict   (verdict),
    .cache_out (cache_out)
);
